// ----- design/rgfi_pkg.sv -----
// shared types and constants of the row-group field-interleave address generator
// no dependencies; imported by every module of the block

package rgfi_pkg;

	// field widths of the geometry registers
	localparam int CNT_W   = 16;
	localparam int FCNT_W  = 4;
	localparam int UNIT_W  = 9;
	localparam int ORDER_W = 24;
	localparam int FIDX_W  = 3;
	localparam int SIZE_W  = 32;

	// widths of the derived strides and of the full size product
	localparam int SBLK_W  = FCNT_W + UNIT_W;
	localparam int SROW_W  = CNT_W + SBLK_W;
	localparam int MCAND_W = CNT_W + SROW_W;
	localparam int PROD_W  = CNT_W + MCAND_W;
	localparam int STEP_W  = $clog2(CNT_W + 1);

	// finish kinds issued by the controller
	localparam logic [1:0] FIN_NONE    = 2'd0;
	localparam logic [1:0] FIN_IDLE    = 2'd1;
	localparam logic [1:0] FIN_RESTART = 2'd2;
	localparam logic [1:0] FIN_ADV     = 2'd3;

	// products formed by the serial multiplier during a restart
	localparam logic [1:0] MOP_ROW   = 2'd0;
	localparam logic [1:0] MOP_OUTER = 2'd1;
	localparam logic [1:0] MOP_EXP   = 2'd2;
	localparam logic [1:0] MOP_GROUP = 2'd3;

	typedef struct packed {
		logic [CNT_W-1:0]   n_outer;
		logic [CNT_W-1:0]   n_rows;
		logic [CNT_W-1:0]   n_blocks;
		logic [FCNT_W-1:0]  n_fields;
		logic [UNIT_W-1:0]  unit_size;
		logic [CNT_W-1:0]   rows_per_group;
		logic [ORDER_W-1:0] field_order_word;
		logic               pack_mode;
	} cfg_t;

	typedef struct packed {
		logic       capture;
		logic       div_start;
		logic       mul_start;
		logic [1:0] start_op;
		logic       mul_store;
		logic [1:0] store_op;
		logic       adv_a;
		logic       adv_b;
		logic [1:0] fin;
	} cmd_t;

	typedef struct packed {
		logic running;
		logic mul_done;
		logic div_busy;
		logic out_free;
	} sts_t;

endpackage

// ----- design/rgfi_mul.sv -----
// shift-add multiplier, one multiplier bit per cycle
// depends on rgfi_pkg for operand and product widths

module rgfi_mul (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         start,
	input  logic [rgfi_pkg::MCAND_W-1:0] mcand,
	input  logic [rgfi_pkg::CNT_W-1:0]   mplier,
	output logic [rgfi_pkg::PROD_W-1:0]  product,
	output logic                         busy,
	output logic                         done
);
	import rgfi_pkg::*;

	logic [PROD_W-1:0] acc_q;
	logic [PROD_W-1:0] shift_q;
	logic [CNT_W-1:0]  mpl_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic              done_q;

	// step counter and handshake flags
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= STEP_W'(CNT_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - STEP_W'(1);
				if (cnt_q == STEP_W'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	// accumulate shifted multiplicand
	always_ff @(posedge clk) begin
		if (start) begin
			acc_q   <= '0;
			shift_q <= PROD_W'(mcand);
			mpl_q   <= mplier;
		end else if (busy_q) begin
			if (mpl_q[0]) begin
				acc_q <= acc_q + shift_q;
			end
			shift_q <= shift_q << 1;
			mpl_q   <= mpl_q >> 1;
		end
	end

	assign product = acc_q;
	assign busy    = busy_q;
	assign done    = done_q;

endmodule

// ----- design/rgfi_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on rgfi_pkg for the operand width

module rgfi_div (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       start,
	input  logic [rgfi_pkg::CNT_W-1:0] dividend,
	input  logic [rgfi_pkg::CNT_W-1:0] divisor,
	output logic [rgfi_pkg::CNT_W-1:0] quotient,
	output logic [rgfi_pkg::CNT_W-1:0] remainder,
	output logic                       busy
);
	import rgfi_pkg::*;

	logic [CNT_W-1:0]  rem_q;
	logic [CNT_W-1:0]  quo_q;
	logic [CNT_W-1:0]  dsor_q;
	logic [STEP_W-1:0] cnt_q;
	logic              busy_q;
	logic [CNT_W:0]    trial;
	logic [CNT_W:0]    diff;
	logic              ge;

	// trial subtract of the next partial remainder
	always_comb begin
		trial = {rem_q, quo_q[CNT_W-1]};
		diff  = trial - {1'b0, dsor_q};
		ge    = trial >= {1'b0, dsor_q};
	end

	// step counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			cnt_q  <= '0;
		end else if (start) begin
			busy_q <= 1'b1;
			cnt_q  <= STEP_W'(CNT_W);
		end else if (busy_q) begin
			cnt_q <= cnt_q - STEP_W'(1);
			if (cnt_q == STEP_W'(1)) begin
				busy_q <= 1'b0;
			end
		end
	end

	// remainder and quotient shift registers
	always_ff @(posedge clk) begin
		if (start) begin
			rem_q  <= '0;
			quo_q  <= dividend;
			dsor_q <= divisor;
		end else if (busy_q) begin
			rem_q <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
			quo_q <= {quo_q[CNT_W-2:0], ge};
		end
	end

	assign quotient  = quo_q;
	assign remainder = rem_q;
	assign busy      = busy_q;

endmodule

// ----- design/rgfi_dp.sv -----
// datapath: latched geometry, strides, walk counters, offset sums and result register
// depends on rgfi_pkg, rgfi_mul and rgfi_div

module rgfi_dp #(
	parameter int MAX_FIELDS  = 8,
	parameter int OFFSET_BITS = 32
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  rgfi_pkg::cmd_t              cmd,
	output rgfi_pkg::sts_t              sts,
	input  rgfi_pkg::cfg_t              cfg,
	input  logic [rgfi_pkg::SIZE_W-1:0] src_bytes,
	input  logic [rgfi_pkg::SIZE_W-1:0] dst_bytes,
	input  logic                        result_stall,
	output logic                        result_valid,
	output logic                        active,
	output logic [rgfi_pkg::SIZE_W-1:0] read_offset,
	output logic [rgfi_pkg::SIZE_W-1:0] write_offset,
	output logic                        last_unit,
	output logic [1:0]                  error_code
);
	import rgfi_pkg::*;

	localparam int ACC_W  = OFFSET_BITS;
	localparam int PP_W   = (OFFSET_BITS < SIZE_W) ? OFFSET_BITS : SIZE_W;
	localparam int SLOT_W = (MAX_FIELDS > 1) ? $clog2(MAX_FIELDS) : 1;
	localparam int SF_W   = FIDX_W + UNIT_W;

	localparam logic [1:0] ERR_OK    = 2'd0;
	localparam logic [1:0] ERR_GROUP = 2'd1;
	localparam logic [1:0] ERR_SIZE  = 2'd2;
	localparam logic [1:0] ERR_FIELD = 2'd3;

	// geometry and sizes latched at restart
	cfg_t              lc_q;
	logic [SIZE_W-1:0] ssize_q;
	logic [SIZE_W-1:0] dsize_q;

	// strides and expected size
	logic [SROW_W-1:0] srow_q;
	logic [ACC_W-1:0]  souter_q;
	logic [ACC_W-1:0]  sgroup_q;
	logic [PROD_W-1:0] expected_q;
	logic [SBLK_W-1:0] sblk;

	// walk state
	logic              running_q;
	logic [CNT_W-1:0]  outer_q;
	logic [CNT_W-1:0]  group_q;
	logic [CNT_W-1:0]  block_q;
	logic [SLOT_W-1:0] slot_q;
	logic [CNT_W-1:0]  lane_q;
	logic [PP_W-1:0]   pack_pos_q;
	logic [ACC_W-1:0]  outer_base_q;
	logic [ACC_W-1:0]  group_base_q;
	logic [ACC_W-1:0]  block_off_q;
	logic [ACC_W-1:0]  lane_off_q;

	// offset sum stages
	logic [ACC_W-1:0]  sa_s1;
	logic [ACC_W-1:0]  sb_s1;
	logic [FIDX_W-1:0] field_s1;
	logic              bad_s1;
	logic [ACC_W-1:0]  sc_s2;
	logic [SF_W-1:0]   sf_s2;
	logic              bad_s2;

	// result register
	logic              out_valid_q;
	logic              active_q;
	logic [SIZE_W-1:0] rd_q;
	logic [SIZE_W-1:0] wr_q;
	logic              last_q;
	logic [1:0]        err_q;

	// arithmetic units
	logic [MCAND_W-1:0] mul_a;
	logic [CNT_W-1:0]   mul_b;
	logic [PROD_W-1:0]  prod;
	logic               mul_busy;
	logic               mul_done;
	logic [CNT_W-1:0]   groups;
	logic [CNT_W-1:0]   rem;
	logic               div_busy;

	// combinational terms
	logic [ORDER_W-1:0] order_sh;
	logic [FIDX_W-1:0]  field;
	logic [ACC_W-1:0]   canon;
	logic               lane_wrap;
	logic               slot_wrap;
	logic               block_wrap;
	logic               group_wrap;
	logic               outer_wrap;
	logic               err_group;
	logic               err_size;
	logic               restart_ok;
	logic               fin_active;
	logic [SIZE_W-1:0]  fin_rd;
	logic [SIZE_W-1:0]  fin_wr;
	logic               fin_last;
	logic [1:0]         fin_err;
	logic               out_free;

	assign sblk = SBLK_W'(lc_q.n_fields) * SBLK_W'(lc_q.unit_size);

	// multiplier operand select
	always_comb begin
		case (cmd.start_op)
			MOP_OUTER: begin
				mul_a = MCAND_W'(prod);
				mul_b = lc_q.n_rows;
			end
			MOP_EXP: begin
				mul_a = MCAND_W'(prod);
				mul_b = lc_q.n_outer;
			end
			MOP_GROUP: begin
				mul_a = MCAND_W'(srow_q);
				mul_b = lc_q.rows_per_group;
			end
			default: begin
				mul_a = MCAND_W'(sblk);
				mul_b = lc_q.n_blocks;
			end
		endcase
	end

	rgfi_mul u_mul (
		.clk     (clk),
		.arst_n  (arst_n),
		.start   (cmd.mul_start),
		.mcand   (mul_a),
		.mplier  (mul_b),
		.product (prod),
		.busy    (mul_busy),
		.done    (mul_done)
	);

	rgfi_div u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (cmd.div_start),
		.dividend  (lc_q.n_rows),
		.divisor   (lc_q.rows_per_group),
		.quotient  (groups),
		.remainder (rem),
		.busy      (div_busy)
	);

	// field index of the current order slot and wrap conditions
	always_comb begin
		order_sh   = lc_q.field_order_word >> (5'(slot_q) * 5'(FIDX_W));
		field      = order_sh[FIDX_W-1:0];
		canon      = sc_s2 + ACC_W'(sf_s2);
		lane_wrap  = ({1'b0, lane_q} + 17'd1) >= {1'b0, lc_q.rows_per_group};
		slot_wrap  = (FCNT_W'(slot_q) + FCNT_W'(1)) >= lc_q.n_fields;
		block_wrap = ({1'b0, block_q} + 17'd1) >= {1'b0, lc_q.n_blocks};
		group_wrap = ({1'b0, group_q} + 17'd1) >= {1'b0, groups};
		outer_wrap = ({1'b0, outer_q} + 17'd1) >= {1'b0, lc_q.n_outer};
	end

	// restart validation
	always_comb begin
		err_group = (lc_q.rows_per_group == '0) || (rem != '0) ||
			(lc_q.n_fields == '0) || (32'(lc_q.n_fields) > MAX_FIELDS);
		err_size = ((expected_q >> OFFSET_BITS) != '0) ||
			(expected_q != PROD_W'(ssize_q)) || (expected_q != PROD_W'(dsize_q));
		restart_ok = !err_group && !err_size;
	end

	// result of the finishing item
	always_comb begin
		fin_active = 1'b0;
		fin_rd     = '0;
		fin_wr     = '0;
		fin_last   = 1'b0;
		fin_err    = ERR_OK;
		case (cmd.fin)
			FIN_RESTART: begin
				if (err_group) begin
					fin_err = ERR_GROUP;
				end else if (err_size) begin
					fin_err = ERR_SIZE;
				end
			end
			FIN_ADV: begin
				if (bad_s2) begin
					fin_err = ERR_FIELD;
				end else begin
					fin_active = 1'b1;
					fin_rd     = lc_q.pack_mode ? SIZE_W'(canon) : SIZE_W'(pack_pos_q);
					fin_wr     = lc_q.pack_mode ? SIZE_W'(pack_pos_q) : SIZE_W'(canon);
					fin_last   = lane_wrap && slot_wrap && block_wrap && group_wrap &&
						outer_wrap;
				end
			end
			default: begin
			end
		endcase
	end

	// geometry capture, stride stores and offset sum stages
	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			lc_q    <= cfg;
			ssize_q <= src_bytes;
			dsize_q <= dst_bytes;
		end
		if (cmd.mul_store) begin
			case (cmd.store_op)
				MOP_ROW:   srow_q     <= SROW_W'(prod);
				MOP_OUTER: souter_q   <= ACC_W'(prod);
				MOP_EXP:   expected_q <= prod;
				default:   sgroup_q   <= ACC_W'(prod);
			endcase
		end
		if (cmd.adv_a) begin
			sa_s1    <= outer_base_q + group_base_q;
			sb_s1    <= lane_off_q + block_off_q;
			field_s1 <= field;
			bad_s1   <= {1'b0, field} >= lc_q.n_fields;
		end
		if (cmd.adv_b) begin
			sc_s2  <= sa_s1 + sb_s1;
			sf_s2  <= SF_W'(field_s1) * SF_W'(lc_q.unit_size);
			bad_s2 <= bad_s1;
		end
		if (cmd.fin != FIN_NONE) begin
			active_q <= fin_active;
			rd_q     <= fin_rd;
			wr_q     <= fin_wr;
			last_q   <= fin_last;
			err_q    <= fin_err;
		end
	end

	// walk counters and running offsets
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			running_q    <= 1'b0;
			outer_q      <= '0;
			group_q      <= '0;
			block_q      <= '0;
			slot_q       <= '0;
			lane_q       <= '0;
			pack_pos_q   <= '0;
			outer_base_q <= '0;
			group_base_q <= '0;
			block_off_q  <= '0;
			lane_off_q   <= '0;
		end else if (cmd.capture) begin
			// a restart ends any walk as soon as the new geometry is latched
			running_q <= 1'b0;
		end else if (cmd.fin == FIN_RESTART) begin
			running_q <= restart_ok && (expected_q != '0);
			if (restart_ok) begin
				outer_q      <= '0;
				group_q      <= '0;
				block_q      <= '0;
				slot_q       <= '0;
				lane_q       <= '0;
				pack_pos_q   <= '0;
				outer_base_q <= '0;
				group_base_q <= '0;
				block_off_q  <= '0;
				lane_off_q   <= '0;
			end
		end else if (cmd.fin == FIN_ADV) begin
			if (bad_s2) begin
				running_q <= 1'b0;
			end else begin
				pack_pos_q <= pack_pos_q + PP_W'(lc_q.unit_size);
				if (!lane_wrap) begin
					lane_q     <= lane_q + CNT_W'(1);
					lane_off_q <= lane_off_q + ACC_W'(srow_q);
				end else begin
					lane_q     <= '0;
					lane_off_q <= '0;
					if (!slot_wrap) begin
						slot_q <= slot_q + SLOT_W'(1);
					end else begin
						slot_q <= '0;
						if (!block_wrap) begin
							block_q     <= block_q + CNT_W'(1);
							block_off_q <= block_off_q + ACC_W'(sblk);
						end else begin
							block_q     <= '0;
							block_off_q <= '0;
							if (!group_wrap) begin
								group_q      <= group_q + CNT_W'(1);
								group_base_q <= group_base_q + sgroup_q;
							end else begin
								group_q      <= '0;
								group_base_q <= '0;
								if (!outer_wrap) begin
									outer_q      <= outer_q + CNT_W'(1);
									outer_base_q <= outer_base_q + souter_q;
								end else begin
									outer_q      <= '0;
									outer_base_q <= '0;
									running_q    <= 1'b0;
								end
							end
						end
					end
				end
			end
		end
	end

	// result register valid flag
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.fin != FIN_NONE) begin
			out_valid_q <= 1'b1;
		end else if (!result_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_free     = !out_valid_q || !result_stall;
	assign sts.running  = running_q;
	assign sts.mul_done = mul_done;
	assign sts.div_busy = div_busy;
	assign sts.out_free = out_free;

	assign result_valid = out_valid_q;
	assign active       = active_q;
	assign read_offset  = rd_q;
	assign write_offset = wr_q;
	assign last_unit    = last_q;
	assign error_code   = err_q;

	// a unit is only emitted from a running walk
	a_adv_running: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin == FIN_ADV |-> running_q)
		else $error("advance finished while walk not running");

	// a running walk has a legal field count
	a_run_fields: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (lc_q.n_fields != '0 && 32'(lc_q.n_fields) <= MAX_FIELDS))
		else $error("walk running with illegal field count");

	// lane and slot counters stay inside the latched geometry
	a_run_bounds: assert property (@(posedge clk) disable iff (!arst_n)
		running_q |-> (lane_q < lc_q.rows_per_group &&
			FCNT_W'(slot_q) < lc_q.n_fields))
		else $error("walk counter outside geometry");

	// the multiplier is never restarted mid-product
	a_mul_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.mul_start |-> !mul_busy)
		else $error("multiplier started while busy");

	// the result register is never overwritten while a result waits
	a_out_free: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.fin != FIN_NONE |-> out_free)
		else $error("result overwritten while stalled");

endmodule

// ----- design/rgfi_ctrl.sv -----
// controller state machine: sequences restart validation, unit advance and transfers with no walk running
// depends on rgfi_pkg for the command and status structs

module rgfi_ctrl (
	input  logic           clk,
	input  logic           arst_n,
	input  logic           item_valid,
	input  logic           restart,
	output logic           item_stall,
	output rgfi_pkg::cmd_t cmd,
	input  rgfi_pkg::sts_t sts
);
	import rgfi_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_PREP = 4'd1;
	localparam logic [3:0] S_MROW = 4'd2;
	localparam logic [3:0] S_MOUT = 4'd3;
	localparam logic [3:0] S_MEXP = 4'd4;
	localparam logic [3:0] S_MGRP = 4'd5;
	localparam logic [3:0] S_FINR = 4'd6;
	localparam logic [3:0] S_ADVA = 4'd7;
	localparam logic [3:0] S_ADVB = 4'd8;
	localparam logic [3:0] S_ADVC = 4'd9;
	localparam logic [3:0] S_FINI = 4'd10;

	logic [3:0] state_q;
	logic [3:0] state_nxt;

	// next state and commands
	always_comb begin
		state_nxt  = state_q;
		cmd        = '0;
		item_stall = (state_q != S_IDLE);
		unique case (state_q)
			S_IDLE: begin
				if (item_valid) begin
					if (restart) begin
						cmd.capture = 1'b1;
						state_nxt   = S_PREP;
					end else if (sts.running) begin
						state_nxt = S_ADVA;
					end else begin
						state_nxt = S_FINI;
					end
				end
			end
			S_PREP: begin
				cmd.mul_start = 1'b1;
				cmd.start_op  = MOP_ROW;
				cmd.div_start = 1'b1;
				state_nxt     = S_MROW;
			end
			S_MROW: begin
				if (sts.mul_done) begin
					cmd.mul_store = 1'b1;
					cmd.store_op  = MOP_ROW;
					cmd.mul_start = 1'b1;
					cmd.start_op  = MOP_OUTER;
					state_nxt     = S_MOUT;
				end
			end
			S_MOUT: begin
				if (sts.mul_done) begin
					cmd.mul_store = 1'b1;
					cmd.store_op  = MOP_OUTER;
					cmd.mul_start = 1'b1;
					cmd.start_op  = MOP_EXP;
					state_nxt     = S_MEXP;
				end
			end
			S_MEXP: begin
				if (sts.mul_done) begin
					cmd.mul_store = 1'b1;
					cmd.store_op  = MOP_EXP;
					cmd.mul_start = 1'b1;
					cmd.start_op  = MOP_GROUP;
					state_nxt     = S_MGRP;
				end
			end
			S_MGRP: begin
				if (sts.mul_done) begin
					cmd.mul_store = 1'b1;
					cmd.store_op  = MOP_GROUP;
					state_nxt     = S_FINR;
				end
			end
			S_FINR: begin
				if (sts.out_free && !sts.div_busy) begin
					cmd.fin   = FIN_RESTART;
					state_nxt = S_IDLE;
				end
			end
			S_ADVA: begin
				cmd.adv_a = 1'b1;
				state_nxt = S_ADVB;
			end
			S_ADVB: begin
				cmd.adv_b = 1'b1;
				state_nxt = S_ADVC;
			end
			S_ADVC: begin
				if (sts.out_free) begin
					cmd.fin   = FIN_ADV;
					state_nxt = S_IDLE;
				end
			end
			S_FINI: begin
				if (sts.out_free) begin
					cmd.fin   = FIN_IDLE;
					state_nxt = S_IDLE;
				end
			end
			default: begin
				state_nxt = S_IDLE;
			end
		endcase
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_nxt;
		end
	end

endmodule

// ----- design/row_group_field_interleave_agen.sv -----
// row-group field-interleave address generator: top level with register port
// advance transfer: adder stages ADVA and ADVB, then ADVC registers the result
// restart transfer: result follows four serial products with 16-bit multipliers; items stall until idle
// transfer with no walk running: result registered in FINI once the output is free
// asynchronous reset: config registers take defaults, the walk is idle until a restart

module row_group_field_interleave_agen #(
	parameter int MAX_FIELDS  = 8,
	parameter int OFFSET_BITS = 32
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        psel,
	input  logic        penable,
	input  logic        pwrite,
	input  logic [4:0]  paddr,
	input  logic [31:0] pwdata,
	output logic [31:0] prdata,
	output logic        pready,
	input  logic        item_valid,
	output logic        item_stall,
	input  logic        restart,
	input  logic [31:0] src_bytes,
	input  logic [31:0] dst_bytes,
	output logic        result_valid,
	input  logic        result_stall,
	output logic        active,
	output logic [31:0] read_offset,
	output logic [31:0] write_offset,
	output logic        last_unit,
	output logic [1:0]  error_code
);
	import rgfi_pkg::*;

	localparam logic [2:0] REG_OUTER = 3'd0;
	localparam logic [2:0] REG_ROWS  = 3'd1;
	localparam logic [2:0] REG_BLOCK = 3'd2;
	localparam logic [2:0] REG_FIELD = 3'd3;
	localparam logic [2:0] REG_UNIT  = 3'd4;
	localparam logic [2:0] REG_RPG   = 3'd5;
	localparam logic [2:0] REG_ORDER = 3'd6;
	localparam logic [2:0] REG_PACK  = 3'd7;

	cfg_t       cfg_q;
	cmd_t       cmd;
	sts_t       sts;
	logic       wr_en;
	logic [2:0] reg_idx;

	assign pready  = 1'b1;
	assign wr_en   = psel && penable && pwrite;
	assign reg_idx = paddr[4:2];

	// register writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.n_outer          <= CNT_W'(1);
			cfg_q.n_rows           <= CNT_W'(1);
			cfg_q.n_blocks         <= CNT_W'(1);
			cfg_q.n_fields         <= FCNT_W'(1);
			cfg_q.unit_size        <= UNIT_W'(1);
			cfg_q.rows_per_group   <= CNT_W'(1);
			cfg_q.field_order_word <= '0;
			cfg_q.pack_mode        <= 1'b1;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_OUTER: cfg_q.n_outer          <= pwdata[CNT_W-1:0];
				REG_ROWS:  cfg_q.n_rows           <= pwdata[CNT_W-1:0];
				REG_BLOCK: cfg_q.n_blocks         <= pwdata[CNT_W-1:0];
				REG_FIELD: cfg_q.n_fields         <= pwdata[FCNT_W-1:0];
				REG_UNIT:  cfg_q.unit_size        <= pwdata[UNIT_W-1:0];
				REG_RPG:   cfg_q.rows_per_group   <= pwdata[CNT_W-1:0];
				REG_ORDER: cfg_q.field_order_word <= pwdata[ORDER_W-1:0];
				REG_PACK:  cfg_q.pack_mode        <= pwdata[0];
				default: begin
				end
			endcase
		end
	end

	// register reads
	always_comb begin
		unique case (reg_idx)
			REG_OUTER: prdata = 32'(cfg_q.n_outer);
			REG_ROWS:  prdata = 32'(cfg_q.n_rows);
			REG_BLOCK: prdata = 32'(cfg_q.n_blocks);
			REG_FIELD: prdata = 32'(cfg_q.n_fields);
			REG_UNIT:  prdata = 32'(cfg_q.unit_size);
			REG_RPG:   prdata = 32'(cfg_q.rows_per_group);
			REG_ORDER: prdata = 32'(cfg_q.field_order_word);
			REG_PACK:  prdata = 32'(cfg_q.pack_mode);
			default:   prdata = '0;
		endcase
	end

	rgfi_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (item_valid),
		.restart    (restart),
		.item_stall (item_stall),
		.cmd        (cmd),
		.sts        (sts)
	);

	rgfi_dp #(
		.MAX_FIELDS  (MAX_FIELDS),
		.OFFSET_BITS (OFFSET_BITS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg          (cfg_q),
		.src_bytes    (src_bytes),
		.dst_bytes    (dst_bytes),
		.result_stall (result_stall),
		.result_valid (result_valid),
		.active       (active),
		.read_offset  (read_offset),
		.write_offset (write_offset),
		.last_unit    (last_unit),
		.error_code   (error_code)
	);

endmodule

// ----- test/tb_row_group_field_interleave_agen.sv -----
// self-checking testbench for the row-group field-interleave address generator
// depends on rgfi_pkg and row_group_field_interleave_agen; predicts every descriptor
// in-line and checks each one against the block's output, under random idling
`timescale 1ns / 1ps

module tb_row_group_field_interleave_agen;
	import rgfi_pkg::*;

	localparam int MAX_FIELDS  = 8;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int SHOW_LIMIT  = 10;

	// register indexes on the config port
	localparam logic [2:0] REG_OUTER = 3'd0;
	localparam logic [2:0] REG_ROWS  = 3'd1;
	localparam logic [2:0] REG_BLOCK = 3'd2;
	localparam logic [2:0] REG_FIELD = 3'd3;
	localparam logic [2:0] REG_UNIT  = 3'd4;
	localparam logic [2:0] REG_RPG   = 3'd5;
	localparam logic [2:0] REG_ORDER = 3'd6;
	localparam logic [2:0] REG_PACK  = 3'd7;

	// status codes reported with each descriptor
	localparam logic [1:0] ERR_NONE  = 2'd0;
	localparam logic [1:0] ERR_GROUP = 2'd1;
	localparam logic [1:0] ERR_SIZE  = 2'd2;
	localparam logic [1:0] ERR_FIELD = 2'd3;

	typedef struct packed {
		logic        active;
		logic [31:0] rd;
		logic [31:0] wr;
		logic        last;
		logic [1:0]  err;
	} unit_desc_t;

	typedef struct {
		logic        restart;
		logic [31:0] ssize;
		logic [31:0] dsize;
		logic        drain;
	} xfer_req_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        psel = 1'b0;
	logic        penable = 1'b0;
	logic        pwrite = 1'b0;
	logic [4:0]  paddr = '0;
	logic [31:0] pwdata = '0;
	logic [31:0] prdata;
	logic        pready;
	logic        item_valid = 1'b0;
	logic        item_stall;
	logic        restart = 1'b0;
	logic [31:0] src_bytes = '0;
	logic [31:0] dst_bytes = '0;
	logic        result_valid;
	logic        result_stall = 1'b0;
	logic        active;
	logic [31:0] read_offset;
	logic [31:0] write_offset;
	logic        last_unit;
	logic [1:0]  error_code;

	row_group_field_interleave_agen uut (
		.clk(clk), .arst_n(arst_n),
		.psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
		.pwdata(pwdata), .prdata(prdata), .pready(pready),
		.item_valid(item_valid), .item_stall(item_stall), .restart(restart),
		.src_bytes(src_bytes), .dst_bytes(dst_bytes),
		.result_valid(result_valid), .result_stall(result_stall),
		.active(active), .read_offset(read_offset), .write_offset(write_offset),
		.last_unit(last_unit), .error_code(error_code)
	);

	always #10 clk = ~clk;

	xfer_req_t  pending_xfers[$];
	unit_desc_t expected_units[$];
	int unsigned items_taken = 0;
	int unsigned results_seen = 0;
	int unsigned fail_count = 0;
	int unsigned cycle_count = 0;
	int          random_items = 0;

	// shadow of the register file and the walk latched at restart
	cfg_t        cfg_regs;
	cfg_t        walk_geo;
	int          walk_groups, walk_outer, walk_group, walk_block, walk_slot, walk_lane;
	logic [31:0] walk_pos;
	bit          walking;

	// next descriptor for one accepted transfer
	function automatic void predict_unit(logic rst, logic [31:0] ss, logic [31:0] ds);
		unit_desc_t      d;
		longint unsigned total, row, canon;
		logic [2:0]      fidx;
		d = '0;
		d.err = ERR_NONE;
		if (rst) begin
			walking = 1'b0;
			if (cfg_regs.rows_per_group == 0 ||
					(cfg_regs.n_rows % cfg_regs.rows_per_group) != 0 ||
					cfg_regs.n_fields == 0 || cfg_regs.n_fields > MAX_FIELDS) begin
				d.err = ERR_GROUP;
			end else begin
				total = cfg_regs.n_outer;
				total = total * cfg_regs.n_rows * cfg_regs.n_blocks *
					cfg_regs.n_fields * cfg_regs.unit_size;
				if (total > 64'hFFFF_FFFF || ss != total || ds != total) begin
					d.err = ERR_SIZE;
				end else begin
					walk_geo = cfg_regs;
					walk_groups = cfg_regs.n_rows / cfg_regs.rows_per_group;
					walk_outer = 0; walk_group = 0; walk_block = 0;
					walk_slot = 0; walk_lane = 0; walk_pos = '0;
					walking = (total != 0);
				end
			end
		end else if (walking) begin
			fidx = walk_geo.field_order_word[3*walk_slot +: 3];
			if (fidx >= walk_geo.n_fields) begin
				d.err = ERR_FIELD;
				walking = 1'b0;
			end else begin
				row = walk_group;
				row = row * walk_geo.rows_per_group + walk_lane;
				canon = walk_outer;
				canon = ((canon * walk_geo.n_rows + row) * walk_geo.n_blocks +
					walk_block) * walk_geo.n_fields + fidx;
				canon = canon * walk_geo.unit_size;
				d.active = 1'b1;
				d.rd = walk_geo.pack_mode ? canon[31:0] : walk_pos;
				d.wr = walk_geo.pack_mode ? walk_pos : canon[31:0];
				walk_pos = walk_pos + walk_geo.unit_size;
				// lane, field slot, block, group, outer, innermost first
				if (++walk_lane >= walk_geo.rows_per_group) begin
					walk_lane = 0;
					if (++walk_slot >= walk_geo.n_fields) begin
						walk_slot = 0;
						if (++walk_block >= walk_geo.n_blocks) begin
							walk_block = 0;
							if (++walk_group >= walk_groups) begin
								walk_group = 0;
								if (++walk_outer >= walk_geo.n_outer) begin
									walk_outer = 0;
									d.last = 1'b1;
									walking = 1'b0;
								end
							end
						end
					end
				end
			end
		end
		expected_units.push_back(d);
	endfunction

	// sender: one gap per transfer, drain points hold until all descriptors are back
	int unsigned send_gap = 0;
	bit          tx_calm = 1'b0;

	always @(posedge clk or negedge arst_n) begin : sender
		xfer_req_t nxt;
		if (!arst_n) begin
			item_valid <= 1'b0;
			send_gap <= 0;
		end else begin
			if (item_valid && !item_stall) begin
				predict_unit(restart, src_bytes, dst_bytes);
				items_taken <= items_taken + 1;
			end
			if (!item_valid || !item_stall) begin
				if (send_gap != 0) begin
					send_gap <= send_gap - 1;
					item_valid <= 1'b0;
				end else if (pending_xfers.size() != 0 && (!pending_xfers[0].drain ||
						(!item_valid && items_taken == results_seen))) begin
					nxt = pending_xfers.pop_front();
					item_valid <= 1'b1;
					restart <= nxt.restart;
					src_bytes <= nxt.ssize;
					dst_bytes <= nxt.dsize;
					send_gap <= tx_calm ? 0 : $urandom_range(0, 8);
					if ($urandom_range(0, 49) == 0)
						tx_calm <= !tx_calm;
				end else begin
					item_valid <= 1'b0;
				end
			end
		end
	end

	// receiver: random stall after each descriptor, compare with the oldest prediction
	int unsigned hold_left = 0;
	bit          rx_calm = 1'b0;

	always @(posedge clk or negedge arst_n) begin : receiver
		unit_desc_t got, want;
		int unsigned n;
		if (!arst_n) begin
			result_stall <= 1'b0;
			hold_left <= 0;
		end else begin
			if (result_valid && !result_stall) begin
				got = {active, read_offset, write_offset, last_unit, error_code};
				results_seen <= results_seen + 1;
				if (expected_units.size() == 0) begin
					fail_count++;
					if (fail_count <= SHOW_LIMIT)
						$display("unexpected transfer: active=%0d rd=%h wr=%h last=%0d err=%0d",
							got.active, got.rd, got.wr, got.last, got.err);
				end else begin
					want = expected_units.pop_front();
					if (got !== want) begin
						fail_count++;
						if (fail_count <= SHOW_LIMIT)
							$display("mismatch: exp active=%0d rd=%h wr=%h last=%0d err=%0d %s %0d %h %h %0d %0d",
								want.active, want.rd, want.wr, want.last, want.err,
								"| got", got.active, got.rd, got.wr, got.last, got.err);
					end
				end
				n = rx_calm ? 0 : $urandom_range(0, 8);
				if ($urandom_range(0, 49) == 0)
					rx_calm <= !rx_calm;
				hold_left <= n;
				result_stall <= (n != 0);
			end else if (hold_left != 0) begin
				hold_left <= hold_left - 1;
				result_stall <= (hold_left > 1);
			end
		end
	end

	// run limit
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("Regression FAIL");
			$finish;
		end
	end

	// block quiet: nothing queued, nothing in flight
	task automatic settle();
		while (pending_xfers.size() != 0 || item_valid || items_taken != results_seen)
			@(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [31:0] val);
		@(posedge clk);
		psel <= 1'b1; penable <= 1'b0; pwrite <= 1'b1;
		paddr <= {idx, 2'b00}; pwdata <= val;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		psel <= 1'b0; penable <= 1'b0; pwrite <= 1'b0;
		case (idx)
			REG_OUTER: cfg_regs.n_outer = val[15:0];
			REG_ROWS:  cfg_regs.n_rows = val[15:0];
			REG_BLOCK: cfg_regs.n_blocks = val[15:0];
			REG_FIELD: cfg_regs.n_fields = val[3:0];
			REG_UNIT:  cfg_regs.unit_size = val[8:0];
			REG_RPG:   cfg_regs.rows_per_group = val[15:0];
			REG_ORDER: cfg_regs.field_order_word = val[23:0];
			REG_PACK:  cfg_regs.pack_mode = val[0];
			default: ;
		endcase
	endtask

	task automatic load_geometry(int outer, int rows, int blocks, int fields, int unit,
			int rpg, int order, int pack);
		settle();
		write_reg(REG_OUTER, outer);
		write_reg(REG_ROWS, rows);
		write_reg(REG_BLOCK, blocks);
		write_reg(REG_FIELD, fields);
		write_reg(REG_UNIT, unit);
		write_reg(REG_RPG, rpg);
		write_reg(REG_ORDER, order);
		write_reg(REG_PACK, pack);
		@(negedge clk);
	endtask

	task automatic queue_xfer(logic rst, logic [31:0] ss, logic [31:0] ds, logic drain = 1'b0);
		xfer_req_t r;
		r.restart = rst; r.ssize = ss; r.dsize = ds; r.drain = drain;
		pending_xfers.push_back(r);
	endtask

	// one random geometry, mostly a full walk with a few broken or aborted transfers
	task automatic random_walk();
		int              outer, rows, blocks, fields, unit, rpg, order, pack, s, idx;
		int              units, mid, j, pick;
		longint unsigned total;
		rpg = $urandom_range(1, 4);
		rows = rpg * $urandom_range(1, 2);
		outer = $urandom_range(1, 2);
		blocks = $urandom_range(1, 3);
		fields = $urandom_range(1, 8);
		case ($urandom_range(0, 6))
			0: unit = 1;
			1: unit = 256;
			2: unit = 511;
			default: unit = $urandom_range(1, 511);
		endcase
		pack = $urandom_range(0, 1);
		if ($urandom_range(0, 9) == 0) begin
			pick = $urandom_range(0, 4);
			case (pick)
				0: rpg = 0;
				1: rpg = rows + 1;
				2: fields = 0;
				3: fields = $urandom_range(9, 15);
				default: begin
					outer = 65535; rows = 65535; blocks = 65535;
					fields = 8; unit = 511; rpg = 1;
				end
			endcase
		end
		order = 0;
		for (s = 0; s < 8; s++) begin
			if (fields == 0 || fields > MAX_FIELDS || $urandom_range(0, 11) == 0)
				idx = $urandom_range(0, 7);
			else
				idx = $urandom_range(0, fields - 1);
			order |= idx << (3 * s);
		end
		if (fields == 8 && $urandom_range(0, 4) == 0)
			order = 24'hFFFFFF;
		load_geometry(outer, rows, blocks, fields, unit, rpg, order, pack);

		total = outer;
		total = total * rows * blocks * fields * unit;
		units = (total > 64'hFFFF_FFFF || unit == 0) ? 2 : int'(total / unit);
		if ($urandom_range(0, 4) == 0)
			repeat ($urandom_range(1, 3)) queue_xfer(1'b0, $urandom, $urandom);
		if ($urandom_range(0, 6) == 0) begin
			case ($urandom_range(0, 2))
				0: queue_xfer(1'b1, total[31:0] + 1, total[31:0]);
				1: queue_xfer(1'b1, total[31:0], total[31:0] - 1);
				default: queue_xfer(1'b1, $urandom, $urandom);
			endcase
		end
		queue_xfer(1'b1, total[31:0], total[31:0]);
		mid = (units > 1 && $urandom_range(0, 9) == 0) ? $urandom_range(1, units - 1) : 0;
		for (j = 0; j < units + mid + $urandom_range(0, 2); j++) begin
			if (mid != 0 && j == mid)
				queue_xfer(1'b1, total[31:0], total[31:0]);
			queue_xfer(1'b0, $urandom, $urandom, $urandom_range(0, 49) == 0);
		end
		random_items += units + mid + 2;
	endtask

	initial begin
		cfg_regs = '{n_outer: 1, n_rows: 1, n_blocks: 1, n_fields: 1,
			unit_size: 1, rows_per_group: 1, field_order_word: 0, pack_mode: 1'b1};
		walking = 1'b0;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset geometry: idle advance, one-unit transfer, size mismatches
		queue_xfer(1'b0, 32'h0, 32'h0);
		queue_xfer(1'b1, 32'd1, 32'd1);
		queue_xfer(1'b0, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		queue_xfer(1'b0, 32'h0, 32'h0);
		queue_xfer(1'b1, 32'd0, 32'd1);
		queue_xfer(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);

		// empty transfer stays idle
		load_geometry(0, 1, 1, 1, 1, 1, 0, 1);
		queue_xfer(1'b1, 32'd0, 32'd0);
		queue_xfer(1'b0, 32'd0, 32'd0);

		// unpack walk over a reordered pair of fields
		load_geometry(1, 2, 1, 2, 256, 2, 1, 0);
		queue_xfer(1'b1, 32'd1024, 32'd1024);
		repeat (4) queue_xfer(1'b0, 32'd0, 32'd0);

		// second slot names a field that does not exist
		load_geometry(1, 2, 1, 3, 256, 2, 7 << 3, 1);
		queue_xfer(1'b1, 32'd1536, 32'd1536);
		repeat (3) queue_xfer(1'b0, 32'd0, 32'd0);

		// bad grouping: zero, non-divisor, no fields, too many fields
		load_geometry(1, 2, 1, 2, 1, 0, 0, 1);
		queue_xfer(1'b1, 32'd4, 32'd4);
		load_geometry(1, 2, 1, 2, 1, 3, 0, 1);
		queue_xfer(1'b1, 32'd4, 32'd4);
		load_geometry(1, 2, 1, 0, 1, 2, 0, 1);
		queue_xfer(1'b1, 32'd0, 32'd0);
		load_geometry(1, 2, 1, 15, 1, 2, 0, 1);
		queue_xfer(1'b1, 32'd30, 32'd30);

		// size past the offset range, then a size near the top of the offset range
		load_geometry(65535, 65535, 65535, 8, 511, 1, 24'hFFFFFF, 1);
		queue_xfer(1'b1, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
		load_geometry(65535, 65535, 1, 1, 1, 65535, 0, 1);
		queue_xfer(1'b1, 32'hFFFE_0001, 32'hFFFE_0001);
		queue_xfer(1'b0, 32'd0, 32'd0);
		queue_xfer(1'b0, 32'd0, 32'd0);

		while (random_items < 1000)
			random_walk();

		settle();
		repeat (8) @(posedge clk);
		if (fail_count == 0 && expected_units.size() == 0)
			$display("Regression PASS");
		else
			$display("Regression FAIL");
		$finish;
	end

endmodule

// ----- filelist.f -----
design/rgfi_pkg.sv
design/rgfi_mul.sv
design/rgfi_div.sv
design/rgfi_dp.sv
design/rgfi_ctrl.sv
design/row_group_field_interleave_agen.sv
test/tb_row_group_field_interleave_agen.sv
